// ===== sv/akb_pkg.sv =====
// Shared types and constants for the ladder ADC key scanner.
// Holds the ladder table, configuration register indexes and event types.
// No dependencies.
package akb_pkg;

  localparam int LADDER_N   = 8;
  localparam int MAX_EVENTS = 4;
  localparam int VOLT_W     = 10;
  localparam int CODE_W     = 8;
  localparam int HOLD_W     = 9;

  localparam logic [CODE_W-1:0] KEY_NONE  = 8'd0;
  localparam logic [CODE_W-1:0] SLEEP_KEY = 8'd62;

  // Ladder voltages and the key codes they map to, in search order.
  localparam logic [VOLT_W-1:0] LADDER_VOLT [LADDER_N] = '{
    10'd535, 10'd435, 10'd321, 10'd111, 10'd8, 10'd721, 10'd220, 10'd626
  };
  localparam logic [CODE_W-1:0] LADDER_CODE [LADDER_N] = '{
    8'd28, 8'd102, 8'd103, 8'd108, 8'd105, 8'd106, 8'd59, 8'd158
  };

  typedef enum logic [2:0] {
    CFG_MATCH_TOL   = 3'd0,
    CFG_SAMPLE_INT  = 3'd1,
    CFG_LONG_PRESS  = 3'd2,
    CFG_SHORT_PRESS = 3'd3,
    CFG_SLEEP_EN    = 3'd4
  } akb_cfg_idx_t;

  typedef struct packed {
    logic [7:0] match_tolerance;
    logic [3:0] sample_interval;
    logic [7:0] long_press_ticks;
    logic [7:0] short_press_ticks;
    logic       sleep_key_enable;
  } akb_cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              down;
  } akb_event_t;

  typedef struct packed {
    akb_event_t [MAX_EVENTS-1:0] ev;
    logic [2:0]                  count;
  } akb_bundle_t;

endpackage

// ===== sv/akb_evq.sv =====
// Event buffer: holds the events of one scan tick and hands them out one per cycle while out_ready is high.
// Depends on akb_pkg.
module akb_evq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  akb_pkg::akb_bundle_t bundle,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_key_code,
  output logic                out_key_down,
  output logic                out_last_event
);
  import akb_pkg::*;

  akb_bundle_t bun_r;
  logic        bun_valid_r, bun_valid_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        pop;
  logic        last;

  assign pop  = bun_valid_r && out_ready;
  assign last = {1'b0, idx_r} == (bun_r.count - 3'd1);
  assign free = !bun_valid_r || (pop && last);

  assign out_valid      = bun_valid_r;
  assign out_key_code   = bun_r.ev[idx_r].code;
  assign out_key_down   = bun_r.ev[idx_r].down;
  assign out_last_event = last;

  always_comb begin
    bun_valid_nxt = bun_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      bun_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end else if (pop && last) begin
      bun_valid_nxt = 1'b0;
    end else if (pop) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bun_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      bun_valid_r <= bun_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bun_r <= bundle;
    end
  end

`ifndef SYNTH
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    bun_valid_r |-> (bun_r.count != 3'd0))
    else $error("event buffer holds an empty bundle");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    bun_valid_r |-> ({1'b0, idx_r} < bun_r.count))
    else $error("event index beyond bundle count");

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("bundle loaded over undelivered events");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && last && !load) |=> !bun_valid_r)
    else $error("buffer still valid after last event taken");
`endif

endmodule

// ===== sv/akb_core.sv =====
// Scan core: input register, tick/settle/held-key/power-hold state and the
// one-pass evaluation that turns a tick into a bundle of events. Depends on akb_pkg.
module akb_core #(
  parameter int ADC_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  akb_pkg::akb_cfg_t    cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ADC_BITS-1:0]  in_adc_sample,
  input  logic                 in_power_pressed,
  input  logic                 evq_free,
  output logic                 evq_load,
  output akb_pkg::akb_bundle_t evq_bundle
);
  import akb_pkg::*;

  localparam int LW = ((ADC_BITS > VOLT_W) ? ADC_BITS : VOLT_W) + 1;

  // Input register
  logic                inq_valid_r, inq_valid_nxt;
  logic [ADC_BITS-1:0] sample_r;
  logic                power_r;
  logic                accept, advance;

  // Scan state
  logic [3:0]          phase_r, phase_nxt;
  logic [1:0]          settle_r, settle_nxt;
  logic [CODE_W-1:0]   held_r, held_nxt;
  logic [HOLD_W-1:0]   hold_r, hold_nxt;

  logic                evaluate;
  logic [LADDER_N-1:0] match;
  logic [CODE_W-1:0]   lookup_code;
  logic [CODE_W-1:0]   code;
  akb_event_t          adc_ev [2];
  akb_event_t          pwr_ev [2];
  logic [2:0]          na, np;
  logic [HOLD_W-1:0]   hold_inc;
  logic                hit_long, hit_double;
  logic [2:0]          slot_rel;

  assign in_ready = !inq_valid_r || evq_free;
  assign accept   = in_valid && in_ready;
  assign advance  = inq_valid_r && evq_free;

  // Ladder compare: one distance check per rung, all in parallel.
  always_comb begin
    logic [LW-1:0] s;
    logic [LW-1:0] v;
    logic [LW-1:0] d;
    s = LW'(sample_r);
    for (int i = 0; i < LADDER_N; i++) begin
      v = LW'(LADDER_VOLT[i]);
      d = (s > v) ? (s - v) : (v - s);
      match[i] = d < LW'(cfg.match_tolerance);
    end
  end

  // First matching rung in table order wins.
  always_comb begin
    lookup_code = KEY_NONE;
    for (int i = LADDER_N - 1; i >= 0; i--) begin
      if (match[i]) begin
        lookup_code = LADDER_CODE[i];
      end
    end
  end

  // ADC path: phase counter, settle skip, press/release on key change.
  always_comb begin
    evaluate   = !(({1'b0, phase_r} + 5'd1) < {1'b0, cfg.sample_interval});
    phase_nxt  = evaluate ? 4'd0 : (phase_r + 4'd1);
    settle_nxt = settle_r;
    held_nxt   = held_r;
    code       = KEY_NONE;
    na         = 3'd0;
    adc_ev[0]  = '{code: held_r, down: 1'b0};
    adc_ev[1]  = '{code: lookup_code, down: 1'b1};
    if (evaluate) begin
      if (settle_r == 2'd0) begin
        settle_nxt = 2'd1;
      end else begin
        code       = lookup_code;
        settle_nxt = 2'd2;
      end
      if (code != KEY_NONE) begin
        if (held_r == KEY_NONE) begin
          adc_ev[0] = '{code: code, down: 1'b1};
          na        = 3'd1;
        end else if (held_r != code) begin
          na = 3'd2;
        end
        held_nxt = code;
      end else if (held_r != KEY_NONE) begin
        na         = 3'd1;
        settle_nxt = 2'd0;
        held_nxt   = KEY_NONE;
      end
    end
  end

  // Power pin: hold counter, long press, auto release, short-press sleep pulse.
  always_comb begin
    hold_inc   = hold_r + 9'd1;
    hit_long   = hold_inc == {1'b0, cfg.long_press_ticks};
    hit_double = hold_inc == {cfg.long_press_ticks, 1'b0};
    hold_nxt   = hold_r;
    np         = 3'd0;
    pwr_ev[0]  = '{code: SLEEP_KEY, down: 1'b1};
    pwr_ev[1]  = '{code: SLEEP_KEY, down: 1'b0};
    if (power_r) begin
      hold_nxt = hit_double ? '0 : hold_inc;
      if (hit_long && hit_double) begin
        np = 3'd2;
      end else if (hit_long) begin
        np = 3'd1;
      end else if (hit_double) begin
        pwr_ev[0] = '{code: SLEEP_KEY, down: 1'b0};
        np        = 3'd1;
      end
    end else if (hold_r > {1'b0, cfg.short_press_ticks}) begin
      hold_nxt = '0;
      if (cfg.sleep_key_enable) begin
        np = 3'd2;
      end
    end
  end

  // Pack ADC events first, power events after them.
  always_comb begin
    slot_rel = 3'd0;
    evq_bundle.count = na + np;
    for (int k = 0; k < MAX_EVENTS; k++) begin
      slot_rel = 3'(k) - na;
      if (3'(k) < na) begin
        evq_bundle.ev[k] = adc_ev[1'(k)];
      end else begin
        evq_bundle.ev[k] = pwr_ev[slot_rel[0]];
      end
    end
  end

  assign evq_load = advance && (evq_bundle.count != 3'd0);

  always_comb begin
    inq_valid_nxt = inq_valid_r;
    if (accept) begin
      inq_valid_nxt = 1'b1;
    end else if (advance) begin
      inq_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      phase_r     <= '0;
      settle_r    <= '0;
      held_r      <= KEY_NONE;
      hold_r      <= '0;
    end else begin
      inq_valid_r <= inq_valid_nxt;
      if (advance) begin
        phase_r  <= phase_nxt;
        settle_r <= settle_nxt;
        held_r   <= held_nxt;
        hold_r   <= hold_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_adc_sample;
      power_r  <= in_power_pressed;
    end
  end

`ifndef SYNTH
  a_settle_range: assert property (@(posedge clk) disable iff (!rst_n)
    settle_r != 2'd3)
    else $error("settle count out of range");

  a_held_needs_settle: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r != KEY_NONE) |-> (settle_r == 2'd2))
    else $error("key held without a settled evaluation");

  a_state_frozen_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(hold_r) && $stable(held_r) && $stable(phase_r)))
    else $error("scan state moved without a tick");
`endif

endmodule

// ===== sv/adc_ladder_key_scanner.sv =====
// Top level of the resistor-ladder ADC key scanner with power-button hold timer.
// Holds the configuration registers; depends on akb_pkg, akb_core and akb_evq.
//
// Each request on the in_ channel is one scan tick. It lands in an input
// register, is evaluated in one pass against the ladder table and the power
// hold counter once the event buffer is free, and its events (zero to four)
// are written to a one-bundle event buffer. Events leave on the out_ channel
// one per cycle while out_ready is high, ADC events first then power events,
// with out_last_event marking the final event of a tick. A tick passes the
// input register and then the event buffer before out_valid rises. While
// out_ready stays high, ticks that give no event or one event sustain one
// tick per cycle; a tick with several events occupies the event buffer until
// its last event is taken, since the buffer delivers a single event per
// cycle, and the next tick waits in the input register meanwhile. Configuration
// is written through cfg_we, cfg_index and cfg_wdata (index 0 tolerance, 1
// interval, 2 long press, 3 short press, 4 sleep enable); write only while the
// block is idle.
module adc_ladder_key_scanner #(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ADC_BITS-1:0] in_adc_sample,
  input  logic                in_power_pressed,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_key_code,
  output logic                out_key_down,
  output logic                out_last_event
);
  import akb_pkg::*;

  akb_cfg_t    cfg_r, cfg_nxt;
  akb_bundle_t bundle;
  logic        evq_load;
  logic        evq_free;

  // Register file: decode the index, drop writes to unused indexes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MATCH_TOL:   cfg_nxt.match_tolerance   = cfg_wdata;
        CFG_SAMPLE_INT:  cfg_nxt.sample_interval   = cfg_wdata[3:0];
        CFG_LONG_PRESS:  cfg_nxt.long_press_ticks  = cfg_wdata;
        CFG_SHORT_PRESS: cfg_nxt.short_press_ticks = cfg_wdata;
        CFG_SLEEP_EN:    cfg_nxt.sleep_key_enable  = cfg_wdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match_tolerance   <= 8'd50;
      cfg_r.sample_interval   <= 4'd5;
      cfg_r.long_press_ticks  <= 8'd100;
      cfg_r.short_press_ticks <= 8'd2;
      cfg_r.sleep_key_enable  <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Evaluate ticks and keep the scan state.
  akb_core #(
    .ADC_BITS(ADC_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_adc_sample   (in_adc_sample),
    .in_power_pressed(in_power_pressed),
    .evq_free        (evq_free),
    .evq_load        (evq_load),
    .evq_bundle      (bundle)
  );

  // Hold the bundle and drain it one event per cycle while out_ready is high.
  akb_evq u_evq (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (evq_load),
    .bundle        (bundle),
    .free          (evq_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_key_code  (out_key_code),
    .out_key_down  (out_key_down),
    .out_last_event(out_last_event)
  );

endmodule

// ===== tb/sv/akb_event_checker.sv =====
// Event checker for the ladder ADC key scanner: watches the tick and event
// channels, predicts the key events of every accepted tick and compares.
// Depends on akb_pkg for widths, the ladder table and register indexes.
module akb_event_checker
  import akb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [VOLT_W-1:0] in_adc_sample,
  input  logic              in_power_pressed,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [CODE_W-1:0] out_key_code,
  input  logic              out_key_down,
  input  logic              out_last_event,
  input  logic              run_done,
  output int                fail_count,
  output int                pending,
  output int                events_checked
);

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              down;
    logic              last;
  } key_event_t;

  key_event_t expected_events[$];

  // Register copy
  logic [7:0] tol_cfg;
  logic [3:0] interval_cfg;
  logic [7:0] long_cfg;
  logic [7:0] short_cfg;
  logic       sleep_en_cfg;

  // Scanner state
  logic [3:0]        scan_phase;
  logic [1:0]        settle_state;
  logic [CODE_W-1:0] pressed_key;
  logic [HOLD_W-1:0] hold_ticks;

  logic leftover_checked;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic key_event_t mk_event(input logic [CODE_W-1:0] code, input logic down);
    key_event_t ev;
    ev.code = code;
    ev.down = down;
    ev.last = 1'b0;
    return ev;
  endfunction

  // First ladder voltage strictly closer than the tolerance wins.
  function automatic logic [CODE_W-1:0] ladder_key(input logic [VOLT_W-1:0] sample);
    int gap;
    for (int i = 0; i < LADDER_N; i++) begin
      gap = int'(sample) - int'(LADDER_VOLT[i]);
      if (gap < 0) gap = -gap;
      if (gap < int'(tol_cfg)) return LADDER_CODE[i];
    end
    return KEY_NONE;
  endfunction

  task automatic predict_scan_tick(input logic [VOLT_W-1:0] sample, input logic pwr);
    key_event_t        evs[$];
    logic [CODE_W-1:0] code;
    code = KEY_NONE;
    // ADC side: evaluate only when the phase counter wraps
    if (int'(scan_phase) + 1 < int'(interval_cfg)) begin
      scan_phase = scan_phase + 4'd1;
    end else begin
      scan_phase = 4'd0;
      if (settle_state == 2'd0) begin
        settle_state = 2'd1;
      end else begin
        code = ladder_key(sample);
        settle_state = 2'd2;
      end
      if (code != KEY_NONE) begin
        if (pressed_key == KEY_NONE) begin
          evs.push_back(mk_event(code, 1'b1));
        end else if (pressed_key != code) begin
          evs.push_back(mk_event(pressed_key, 1'b0));
          evs.push_back(mk_event(code, 1'b1));
        end
        pressed_key = code;
      end else if (pressed_key != KEY_NONE) begin
        evs.push_back(mk_event(pressed_key, 1'b0));
        settle_state = 2'd0;
        pressed_key = KEY_NONE;
      end
    end
    // Power side: hold counter wraps at nine bits
    if (pwr) begin
      hold_ticks = hold_ticks + 9'd1;
      if (int'(hold_ticks) == int'(long_cfg)) evs.push_back(mk_event(SLEEP_KEY, 1'b1));
      if (int'(hold_ticks) == 2 * int'(long_cfg)) begin
        hold_ticks = '0;
        evs.push_back(mk_event(SLEEP_KEY, 1'b0));
      end
    end else if (int'(hold_ticks) > int'(short_cfg)) begin
      hold_ticks = '0;
      if (sleep_en_cfg) begin
        evs.push_back(mk_event(SLEEP_KEY, 1'b1));
        evs.push_back(mk_event(SLEEP_KEY, 1'b0));
      end
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[i]) expected_events.push_back(evs[i]);
  endtask

  always @(posedge clk) begin
    key_event_t want;
    if (!rst_n) begin
      tol_cfg          = 8'd50;
      interval_cfg     = 4'd5;
      long_cfg         = 8'd100;
      short_cfg        = 8'd2;
      sleep_en_cfg     = 1'b1;
      scan_phase       = '0;
      settle_state     = '0;
      pressed_key      = KEY_NONE;
      hold_ticks       = '0;
      fail_count       = 0;
      events_checked   = 0;
      leftover_checked = 1'b0;
      expected_events.delete();
    end else begin
      if (cfg_we) begin
        case (akb_cfg_idx_t'(cfg_index))
          CFG_MATCH_TOL:   tol_cfg      = cfg_wdata;
          CFG_SAMPLE_INT:  interval_cfg = cfg_wdata[3:0];
          CFG_LONG_PRESS:  long_cfg     = cfg_wdata;
          CFG_SHORT_PRESS: short_cfg    = cfg_wdata;
          CFG_SLEEP_EN:    sleep_en_cfg = cfg_wdata[0];
          default: ;
        endcase
      end
      // Compare before predicting: an event never belongs to a tick taken this edge.
      if (out_valid && out_ready) begin
        events_checked++;
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event: code %0d down %0b last %0b",
                                    out_key_code, out_key_down, out_last_event));
        end else begin
          want = expected_events.pop_front();
          if (out_key_code !== want.code || out_key_down !== want.down ||
              out_last_event !== want.last)
            report_mismatch($sformatf(
              "event %0d: got code %0d down %0b last %0b, want code %0d down %0b last %0b",
              events_checked, out_key_code, out_key_down, out_last_event,
              want.code, want.down, want.last));
        end
      end
      if (in_valid && in_ready) predict_scan_tick(in_adc_sample, in_power_pressed);
      // Flag leftovers once at the end of the run.
      if (run_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_events.size() != 0)
          report_mismatch($sformatf("%0d expected events never arrived",
                                    expected_events.size()));
      end
    end
    pending = expected_events.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the ladder ADC key scanner bench: clock, reset, tick stimulus,
// register settings, output back-pressure and the verdict.
// Depends on akb_pkg, adc_ladder_key_scanner and akb_event_checker.
module testbench;
  import akb_pkg::*;

  localparam int RX_HOLD_CYCLES = 200;      // long receiver hold-off
  localparam int DRAIN_PAUSE    = 8;        // zero-event ticks still in flight
  localparam int END_GUARD      = 200000;   // cycles allowed for the final drain
  localparam int RUN_LIMIT      = 4800000;  // time limit for the whole run

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [7:0]        cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [VOLT_W-1:0] in_adc_sample;
  logic              in_power_pressed;
  logic              out_valid;
  logic              out_ready;
  logic [CODE_W-1:0] out_key_code;
  logic              out_key_down;
  logic              out_last_event;
  logic              run_done;

  int fail_count;
  int pending;
  int events_checked;

  // Idle rates in percent, changed between phases.
  int tx_idle_pct;
  int rx_idle_pct;
  // Toggle to ask the receiver for one long hold-off.
  logic rx_hold_req;

  // Settings currently in the block; they shape the random ticks.
  int cur_tol;
  int cur_int;
  int cur_long;
  int cur_short;

  // Random stream state: sample and power level are held for runs of ticks.
  logic [VOLT_W-1:0] run_sample;
  int                sample_left;
  logic              run_power;
  int                power_left;

  int ticks_sent;
  int cfg_sets;

  adc_ladder_key_scanner dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_adc_sample    (in_adc_sample),
    .in_power_pressed (in_power_pressed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_key_code     (out_key_code),
    .out_key_down     (out_key_down),
    .out_last_event   (out_last_event)
  );

  akb_event_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_adc_sample    (in_adc_sample),
    .in_power_pressed (in_power_pressed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_key_code     (out_key_code),
    .out_key_down     (out_key_down),
    .out_last_event   (out_last_event),
    .run_done         (run_done),
    .fail_count       (fail_count),
    .pending          (pending),
    .events_checked   (events_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT);
    $display("Run timed out with %0d events still pending", pending);
    $display("Mismatches found");
    $finish;
  end

  // Receiver: drop out_ready at the configured rate, or hold it low for a
  // long stretch on request so the event buffer and the input register fill.
  initial begin
    logic rx_hold_seen;
    out_ready    = 1'b0;
    rx_hold_seen = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != rx_hold_seen) begin
        rx_hold_seen = rx_hold_req;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one tick request and hold it until the block takes it.
  // Called and returns at a falling edge.
  task automatic send_tick(input logic [VOLT_W-1:0] sample, input logic pwr);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_adc_sample    <= sample;
    in_power_pressed <= pwr;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    ticks_sent++;
  endtask

  // Pause the sender until every predicted event is out, then let any
  // event-free ticks still inside the block finish.
  task automatic drain_events();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  task automatic write_reg(input akb_cfg_idx_t idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Write every register; only call with the block idle.
  task automatic apply_config(input int tol, input int intv, input int lng, input int shrt,
                              input int slp);
    write_reg(CFG_MATCH_TOL, 8'(tol));
    write_reg(CFG_SAMPLE_INT, 8'(intv));
    write_reg(CFG_LONG_PRESS, 8'(lng));
    write_reg(CFG_SHORT_PRESS, 8'(shrt));
    write_reg(CFG_SLEEP_EN, 8'(slp));
    cur_tol   = tol;
    cur_int   = (intv == 0) ? 1 : intv;
    cur_long  = lng;
    cur_short = shrt;
    cfg_sets++;
  endtask

  // Mostly samples that sit near a ladder voltage (inside and just outside
  // the tolerance), held for runs of ticks of random length; the rest is noise and
  // the empty top of the range. Power presses come in short and long holds.
  task automatic next_random_tick(output logic [VOLT_W-1:0] sample, output logic pwr);
    int pick;
    int v;
    int span;
    if (sample_left == 0) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        span = (cur_tol + 8 > 300) ? 300 : cur_tol + 8;
        v = int'(LADDER_VOLT[$urandom_range(LADDER_N - 1)]);
        v = $urandom_range(1) ? v + $urandom_range(span) : v - $urandom_range(span);
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
      end else if (pick < 85) begin
        v = $urandom_range(1023);
      end else begin
        v = 1023 - $urandom_range(40);
      end
      run_sample  = VOLT_W'(v);
      sample_left = $urandom_range(1, 3 * cur_int + 1);
    end
    sample_left--;
    if (power_left == 0) begin
      run_power = ~run_power;
      if (!run_power)
        power_left = $urandom_range(1, 5);
      else if ($urandom_range(1))
        power_left = $urandom_range(1, cur_short + 2);
      else
        power_left = $urandom_range(1, 2 * cur_long + 3);
    end
    power_left--;
    sample = run_sample;
    pwr    = run_power;
  endtask

  task automatic random_ticks(input int count);
    logic [VOLT_W-1:0] s;
    logic              p;
    repeat (count) begin
      next_random_tick(s, p);
      send_tick(s, p);
    end
  endtask

  initial begin
    int guard;
    rst_n            = 1'b0;
    run_done         = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_MATCH_TOL;
    cfg_wdata        = 8'd0;
    in_valid         = 1'b0;
    in_adc_sample    = '0;
    in_power_pressed = 1'b0;
    rx_hold_req      = 1'b0;
    tx_idle_pct      = 35;
    rx_idle_pct      = 75;
    sample_left      = 0;
    power_left       = 0;
    run_sample       = '0;
    run_power        = 1'b0;
    ticks_sent       = 0;
    cfg_sets         = 0;
    cur_tol   = 50;
    cur_int   = 5;
    cur_long  = 100;
    cur_short = 2;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: every tick evaluated, a short long-press window.
    apply_config(50, 1, 3, 1, 1);
    send_tick(10'd1023, 1'b0);  // first evaluation after reset is skipped
    send_tick(10'd535, 1'b0);   // press of the first ladder key
    send_tick(10'd535, 1'b1);   // same key again: no event
    send_tick(10'd435, 1'b1);   // key change: release then press
    send_tick(10'd321, 1'b1);   // key change plus long-press press
    send_tick(10'd111, 1'b0);   // key change plus sleep pulse: four events
    send_tick(10'd8, 1'b0);
    send_tick(10'd0, 1'b0);     // bottom of the range, same key
    send_tick(10'd1023, 1'b1);  // no key: release
    send_tick(10'd721, 1'b0);   // skipped after release; short hold kept
    send_tick(10'd220, 1'b1);   // held count accumulates
    send_tick(10'd626, 1'b1);   // long-press press
    send_tick(10'd626, 1'b1);
    send_tick(10'd626, 1'b1);
    send_tick(10'd626, 1'b1);   // twice the long count: release, counter clears
    send_tick(10'd600, 1'b0);
    send_tick(10'd485, 1'b0);   // exactly at the tolerance: no match
    send_tick(10'd1000, 1'b0);  // skipped evaluation
    send_tick(10'd486, 1'b0);   // just inside the tolerance
    send_tick(10'd683, 1'b0);   // 721 - 38: matches the sixth key
    drain_events();

    random_ticks(20);
    drain_events();

    // Upper extremes, no sleep pulse.
    apply_config(255, 15, 255, 255, 0);
    random_ticks(30);
    drain_events();

    // Sender mostly idle, receiver mostly ready.
    tx_idle_pct = 75;
    rx_idle_pct = 35;

    // Lower extremes: interval zero acts as one, nothing matches.
    apply_config(0, 0, 1, 0, 1);
    random_ticks(20);
    drain_events();

    // Long press count of zero: holds below the nine-bit wrap give no long press.
    apply_config(1, 3, 0, 0, 1);
    random_ticks(10);
    drain_events();

    // No idling; a long receiver stall while the sender keeps offering.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_config($urandom_range(20, 120), $urandom_range(1, 4), $urandom_range(2, 20),
                 $urandom_range(0, 5), $urandom_range(1));
    rx_hold_req = ~rx_hold_req;
    random_ticks(15);
    random_ticks(20);
    drain_events();

    apply_config($urandom_range(1, 255), $urandom_range(0, 15), $urandom_range(1, 30),
                 $urandom_range(0, 10), $urandom_range(1));
    random_ticks(20);

    // Final drain with a bound, then flag leftovers.
    in_valid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < END_GUARD) begin
      @(negedge clk);
      guard++;
    end
    repeat (DRAIN_PAUSE) @(negedge clk);
    run_done <= 1'b1;
    repeat (2) @(negedge clk);

    $display("Covered %0d scan ticks and %0d key events under %0d register settings,",
             ticks_sent, events_checked, cfg_sets);
    $display("incl. both register extremes, shifting back-pressure and a long output stall.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
